// ===== hw/rtl/euler_to_body_gravity_defines.svh =====
// ---------------------------------------------------------------------------
// euler_to_body_gravity assertion macros
// concurrent checks, empty when built for synthesis
// ---------------------------------------------------------------------------
`ifndef EULER_TO_BODY_GRAVITY_DEFINES_SVH
`define EULER_TO_BODY_GRAVITY_DEFINES_SVH

`ifndef SYNTHESIS
`define EG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define EG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define EG_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define EG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/eg_pkg.sv =====
// ---------------------------------------------------------------------------
// eg_pkg
// shared types and constants of the body gravity pipeline
// ---------------------------------------------------------------------------
package eg_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int TRIG_STEPS     = 24;
    localparam int TRIG_W         = 34;
    localparam int OUT_W          = 16;
    localparam int GRAV_W         = 15;
    localparam int CORDIC_LAT     = TRIG_STEPS + 2;

    localparam logic [GRAV_W-1:0] GRAV_RESET = 15'd10045;
    localparam logic [31:0]       CORDIC_GAIN = 32'd652032874;
    localparam int                OUT_LIMIT   = 32767;

    // atan(2^-i), 2^32 units per turn
    localparam logic [31:0] ATAN_TURNS [TRIG_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic signed [TRIG_W-1:0] sin_v;
        logic signed [TRIG_W-1:0] cos_v;
    } t_trig;

    function automatic logic signed [OUT_W-1:0] clamp_out(input logic signed [51:0] v);
        logic signed [51:0] lim;
        lim = 52'(OUT_LIMIT);
        if (v > lim) begin
            return OUT_W'(OUT_LIMIT);
        end else if (v < -lim) begin
            return -OUT_W'(OUT_LIMIT);
        end
        return v[OUT_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/eg_cordic.sv =====
// ---------------------------------------------------------------------------
// eg_cordic
// pipelined rotation-mode cordic, one iteration per stage, sine and cosine in q30
// ---------------------------------------------------------------------------
module eg_cordic #(
    parameter int ANGLE_BITS = eg_pkg::ANGLE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_ce,
    input  logic [15:0]   i_angle,
    output eg_pkg::t_trig o_trig
);
    import eg_pkg::*;

    localparam logic [31:0] KEEP = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    logic signed [TRIG_W-1:0] r_x [TRIG_STEPS+1];
    logic signed [TRIG_W-1:0] r_y [TRIG_STEPS+1];
    logic signed [TRIG_W-1:0] r_z [TRIG_STEPS+1];
    logic [1:0]               r_q [TRIG_STEPS+1];

    logic [31:0] phase;
    logic [31:0] phase_ofs;
    logic [1:0]  quad;
    logic [31:0] resid;

    always_comb begin
        phase     = {i_angle, 16'd0} & KEEP;
        phase_ofs = phase + 32'h2000_0000;
        quad      = phase_ofs[31:30];
        resid     = phase - {quad, 30'd0};
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_x[0] <= TRIG_W'(CORDIC_GAIN);
            r_y[0] <= '0;
            r_z[0] <= TRIG_W'($signed(resid));
            r_q[0] <= quad;
        end
    end

    for (genvar i = 0; i < TRIG_STEPS; i++) begin : g_step
        logic signed [TRIG_W-1:0] dx;
        logic signed [TRIG_W-1:0] dy;
        logic signed [TRIG_W-1:0] at;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;
        assign at = $signed(TRIG_W'(ATAN_TURNS[i]));
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                if (!r_z[i][TRIG_W-1]) begin
                    r_x[i+1] <= r_x[i] - dx;
                    r_y[i+1] <= r_y[i] + dy;
                    r_z[i+1] <= r_z[i] - at;
                end else begin
                    r_x[i+1] <= r_x[i] + dx;
                    r_y[i+1] <= r_y[i] - dy;
                    r_z[i+1] <= r_z[i] + at;
                end
                r_q[i+1] <= r_q[i];
            end
        end
    end

    // fold the quadrant back in
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            case (r_q[TRIG_STEPS])
                2'd0: begin
                    o_trig.cos_v <= r_x[TRIG_STEPS];
                    o_trig.sin_v <= r_y[TRIG_STEPS];
                end
                2'd1: begin
                    o_trig.cos_v <= -r_y[TRIG_STEPS];
                    o_trig.sin_v <= r_x[TRIG_STEPS];
                end
                2'd2: begin
                    o_trig.cos_v <= -r_x[TRIG_STEPS];
                    o_trig.sin_v <= -r_y[TRIG_STEPS];
                end
                default: begin
                    o_trig.cos_v <= r_y[TRIG_STEPS];
                    o_trig.sin_v <= -r_x[TRIG_STEPS];
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/eg_mult.sv =====
// ---------------------------------------------------------------------------
// eg_mult
// products, q30 rounding and saturation, ending in the output register
// ---------------------------------------------------------------------------
`include "euler_to_body_gravity_defines.svh"

module eg_mult (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_ce,
    input  logic                          i_vld,
    input  logic [eg_pkg::GRAV_W-1:0]     i_grav,
    input  eg_pkg::t_trig                 i_roll,
    input  eg_pkg::t_trig                 i_pitch,
    output logic                          o_vld,
    output logic signed [eg_pkg::OUT_W-1:0] o_gx,
    output logic signed [eg_pkg::OUT_W-1:0] o_gy,
    output logic signed [eg_pkg::OUT_W-1:0] o_gz
);
    import eg_pkg::*;

    localparam logic signed [67:0] HALF68 = 68'sd1 <<< 29;
    localparam logic signed [51:0] HALF52 = 52'sd1 <<< 29;

    logic [2:0] r_vld;

    logic signed [67:0] r_src_p, r_crc_p;
    logic signed [51:0] r_gsp;
    logic signed [TRIG_W-1:0] r_src, r_crc;
    logic signed [OUT_W-1:0]  r_gx2, r_gx3;
    logic signed [51:0] r_gy_p, r_gz_p;

    logic signed [15:0] g_s;
    logic signed [67:0] src_r, crc_r;
    logic signed [51:0] gx_r, gy_r, gz_r;

    always_comb begin
        g_s   = $signed({1'b0, i_grav});
        src_r = (r_src_p + HALF68) >>> 30;
        crc_r = (r_crc_p + HALF68) >>> 30;
        gx_r  = (-r_gsp + HALF52) >>> 30;
        gy_r  = (r_gy_p + HALF52) >>> 30;
        gz_r  = (-r_gz_p + HALF52) >>> 30;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            o_vld <= 1'b0;
        end else if (i_ce) begin
            r_vld <= {r_vld[1:0], i_vld};
            o_vld <= r_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_src_p <= 68'(i_roll.sin_v) * 68'(i_pitch.cos_v);
            r_crc_p <= 68'(i_roll.cos_v) * 68'(i_pitch.cos_v);
            r_gsp   <= 52'(g_s) * 52'(i_pitch.sin_v);

            r_src <= src_r[TRIG_W-1:0];
            r_crc <= crc_r[TRIG_W-1:0];
            r_gx2 <= clamp_out(gx_r);

            r_gy_p <= 52'(g_s) * 52'(r_src);
            r_gz_p <= 52'(g_s) * 52'(r_crc);
            r_gx3  <= r_gx2;

            o_gx <= r_gx3;
            o_gy <= clamp_out(gy_r);
            o_gz <= clamp_out(gz_r);
        end
    end

    `EG_ASSERT_NEXT(a_vld_moves, i_clk, i_rst_n, i_ce && r_vld[2], o_vld)
    `EG_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !i_ce, $stable(o_vld) && $stable(o_gy))
    `EG_ASSERT_IMPLY(a_sat_x, i_clk, i_rst_n, o_vld, o_gx != -16'sd32768)
    `EG_ASSERT_IMPLY(a_sat_yz, i_clk, i_rst_n, o_vld, o_gy != -16'sd32768 && o_gz != -16'sd32768)

endmodule

// ===== hw/rtl/euler_to_body_gravity.sv =====
// pipeline: 26 cordic stages, then 4 multiply stages, from input transfer to result
// throughput: one item per cycle while the output is not stalled, set by the fully pipelined cordic and multipliers
// a stall on the output side freezes the whole pipeline; nothing is lost
// reset (i_rst_n low, synchronous) clears all valid bits and loads g = 10045
// ---------------------------------------------------------------------------
// euler_to_body_gravity
// body-frame gravity vector from roll and pitch binary angles
// ---------------------------------------------------------------------------
module euler_to_body_gravity #(
    parameter int ANGLE_BITS = eg_pkg::ANGLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // roll_angle, pitch_angle, yaw_angle
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // gravity_x, gravity_y, gravity_z
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [eg_pkg::GRAV_W-1:0] i_cfg_data
);
    import eg_pkg::*;

    logic                     ce;
    logic [GRAV_W-1:0]        r_grav;
    logic [CORDIC_LAT-1:0]    r_vld;
    t_trig                    roll_trig, pitch_trig;
    logic signed [OUT_W-1:0]  gx, gy, gz;
    logic                     out_vld;

    // yaw (s_axis_tdata[47:32]) drops out of the product

    assign ce            = !out_vld || m_axis_tready;
    assign s_axis_tready = ce;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = out_vld;
    assign m_axis_tdata  = {gz, gy, gx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav <= GRAV_RESET;
        end else if (i_cfg_valid) begin
            r_grav <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[CORDIC_LAT-2:0], s_axis_tvalid};
        end
    end

    eg_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_angle(s_axis_tdata[15:0]),
        .o_trig (roll_trig)
    );

    eg_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_angle(s_axis_tdata[31:16]),
        .o_trig (pitch_trig)
    );

    eg_mult u_mult (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ce   (ce),
        .i_vld  (r_vld[CORDIC_LAT-1]),
        .i_grav (r_grav),
        .i_roll (roll_trig),
        .i_pitch(pitch_trig),
        .o_vld  (out_vld),
        .o_gx   (gx),
        .o_gy   (gy),
        .o_gz   (gz)
    );

endmodule
